// File: hdl/columnar_transposition_decrypt_macros.svh
`ifndef COLUMNAR_TRANSPOSITION_DECRYPT_MACROS_SVH
`define COLUMNAR_TRANSPOSITION_DECRYPT_MACROS_SVH

// same-cycle implication, masked while in reset
`define CTD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ctd check failed");

// next-cycle implication, masked while in reset
`define CTD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ctd check failed");

`endif

// File: hdl/ctd_pkg.sv
`timescale 1ns / 1ps
package ctd_pkg;

  localparam int MAX_COLUMNS_DEF = 16;
  localparam int MAX_ROWS_DEF    = 64;
  localparam int CFG_W           = 5;

  localparam logic [7:0] UNDERSCORE_BYTE = 8'h5F;
  localparam logic [7:0] HASH_BYTE       = 8'h23;
  localparam logic [7:0] SPACE_BYTE      = 8'h20;
  localparam logic [7:0] TAB_BYTE        = 8'h09;
  localparam logic [7:0] CR_BYTE         = 8'h0D;

  typedef enum logic [1:0] {
    CMD_LOAD_KEY = 2'd0,
    CMD_CIPHER   = 2'd1,
    CMD_READ     = 2'd2,
    CMD_RESTART  = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t       command;
    logic [3:0] column_index;
    logic [7:0] key_value;
    logic [7:0] text_byte;
  } in_word_t;

  typedef struct packed {
    logic [7:0] plain_byte;
    logic       byte_valid;
    logic       finished;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WORD_LEN,
    ST_RANK0,
    ST_LEN0,
    ST_RANKC,
    ST_LENC,
    ST_TEXT,
    ST_RESULT
  } ctd_state_t;

  typedef enum logic [1:0] {
    RK_IDLE,
    RK_TARGET,
    RK_SCAN
  } rank_state_t;

endpackage

// File: hdl/ctd_stream_if.sv
`timescale 1ns / 1ps
interface ctd_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// File: hdl/ctd_key_rank.sv
`timescale 1ns / 1ps
module ctd_key_rank #(
  parameter int MAX_COLUMNS = ctd_pkg::MAX_COLUMNS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             key_we,
  input  logic [$clog2(MAX_COLUMNS)-1:0]   key_waddr,
  input  logic [7:0]                       key_wdata,
  input  logic                             start,
  input  logic [$clog2(MAX_COLUMNS)-1:0]   pos,
  input  logic [$clog2(MAX_COLUMNS+1)-1:0] cols,
  output logic                             done,
  output logic [$clog2(MAX_COLUMNS)-1:0]   rank
);

  localparam int CIW = $clog2(MAX_COLUMNS);
  localparam int CNW = $clog2(MAX_COLUMNS+1);

  logic [7:0]             key_mem [MAX_COLUMNS];
  logic [MAX_COLUMNS-1:0] key_vld_r;
  logic [7:0]             key_q_r;
  logic                   kvld_q_r;
  logic [7:0]             key_cur;
  logic [CIW-1:0]         rd_addr;

  ctd_pkg::rank_state_t state_r, state_nxt;
  logic [CNW-1:0] cols_r, cols_nxt;
  logic [CNW-1:0] j_r, j_nxt;
  logic [CIW-1:0] cnt_r, cnt_nxt;
  logic [7:0]     target_r, target_nxt;
  logic [CIW-1:0] rank_r, rank_nxt;
  logic           done_r, done_nxt;
  logic [CIW-1:0] cnt_inc;

  // key memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[key_waddr] <= key_wdata;
    end
    key_q_r  <= key_mem[rd_addr];
    kvld_q_r <= key_vld_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_vld_r <= '0;
    end else if (key_we) begin
      key_vld_r[key_waddr] <= 1'b1;
    end
  end

  assign key_cur = kvld_q_r ? key_q_r : 8'd0;
  assign cnt_inc = cnt_r + CIW'(key_cur < target_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ctd_pkg::RK_IDLE: begin
        if (start) begin
          state_nxt = ctd_pkg::RK_TARGET;
        end
      end
      ctd_pkg::RK_TARGET: begin
        state_nxt = ctd_pkg::RK_SCAN;
      end
      ctd_pkg::RK_SCAN: begin
        if (j_r == cols_r) begin
          state_nxt = ctd_pkg::RK_IDLE;
        end
      end
      default: state_nxt = ctd_pkg::RK_IDLE;
    endcase
  end

  always_comb begin
    rd_addr    = '0;
    cols_nxt   = cols_r;
    j_nxt      = j_r;
    cnt_nxt    = cnt_r;
    target_nxt = target_r;
    rank_nxt   = rank_r;
    done_nxt   = 1'b0;
    unique case (state_r)
      ctd_pkg::RK_IDLE: begin
        rd_addr  = pos;
        cols_nxt = cols;
      end
      ctd_pkg::RK_TARGET: begin
        target_nxt = key_cur;
        rd_addr    = '0;
        j_nxt      = CNW'(1);
        cnt_nxt    = '0;
      end
      ctd_pkg::RK_SCAN: begin
        cnt_nxt = cnt_inc;
        if (j_r == cols_r) begin
          rank_nxt = cnt_inc;
          done_nxt = 1'b1;
        end else begin
          rd_addr = j_r[CIW-1:0];
          j_nxt   = j_r + CNW'(1);
        end
      end
      default: begin
        rd_addr = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ctd_pkg::RK_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cols_r   <= cols_nxt;
    j_r      <= j_nxt;
    cnt_r    <= cnt_nxt;
    target_r <= target_nxt;
    rank_r   <= rank_nxt;
  end

  assign done = done_r;
  assign rank = rank_r;

endmodule

// File: hdl/ctd_text_store.sv
`timescale 1ns / 1ps
module ctd_text_store #(
  parameter int MAX_COLUMNS = ctd_pkg::MAX_COLUMNS_DEF,
  parameter int MAX_ROWS    = ctd_pkg::MAX_ROWS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           clear,
  input  logic [$clog2(MAX_COLUMNS)-1:0] len_raddr,
  output logic [$clog2(MAX_ROWS+1)-1:0]  len_rdata,
  input  logic                           len_we,
  input  logic [$clog2(MAX_COLUMNS)-1:0] len_waddr,
  input  logic [$clog2(MAX_ROWS+1)-1:0]  len_wdata,
  input  logic                           txt_we,
  input  logic                           txt_re,
  input  logic [$clog2(MAX_COLUMNS)-1:0] txt_col,
  input  logic [$clog2(MAX_ROWS)-1:0]    txt_row,
  input  logic [7:0]                     txt_wdata,
  output logic [7:0]                     txt_rdata
);

  localparam int LW    = $clog2(MAX_ROWS+1);
  localparam int DEPTH = MAX_COLUMNS * MAX_ROWS;
  localparam int TAW   = $clog2(DEPTH);

  logic [LW-1:0]          len_mem [MAX_COLUMNS];
  logic [MAX_COLUMNS-1:0] len_vld_r;
  logic [LW-1:0]          len_q_r;
  logic                   lvld_q_r;
  logic [7:0]             txt_mem [DEPTH];
  logic [7:0]             txt_q_r;
  logic [TAW-1:0]         txt_addr;

  // word lengths, cleared by restart through the valid bits
  always_ff @(posedge clk) begin
    if (len_we) begin
      len_mem[len_waddr] <= len_wdata;
    end
    len_q_r  <= len_mem[len_raddr];
    lvld_q_r <= len_vld_r[len_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_vld_r <= '0;
    end else if (clear) begin
      len_vld_r <= '0;
    end else if (len_we) begin
      len_vld_r[len_waddr] <= 1'b1;
    end
  end

  assign len_rdata = lvld_q_r ? len_q_r : '0;

  // word k, byte i lives at k * MAX_ROWS + i
  assign txt_addr = TAW'(txt_col) * TAW'(MAX_ROWS) + TAW'(txt_row);

  always_ff @(posedge clk) begin
    if (txt_we) begin
      txt_mem[txt_addr] <= txt_wdata;
    end
    if (txt_re) begin
      txt_q_r <= txt_mem[txt_addr];
    end
  end

  assign txt_rdata = txt_q_r;

endmodule

// File: hdl/columnar_transposition_decrypt.sv
`timescale 1ns / 1ps
// Columnar transposition decrypter. Load key entries (command 0) and set column_count, then
// send ciphertext bytes (command 1); whitespace splits them into column words kept in the
// text memory. Each read request (command 2) returns one result word: a plaintext byte, or
// finished once the message has ended; restart (command 3) clears the words and read position.
// Key loads, restarts, whitespace bytes and bytes of dropped words are handled in the idle
// state; stored ciphertext bytes take a length memory read, then a text and length write. For
// a read that returns a byte or hits the end marker, the single key comparator sweeps the key
// memory over the N columns in use for position 0, the length of that word is read, the
// comparator sweeps again for the current column, and that word's length and text are read.
// A read may also end at the row 0 word length or find the current column's word exhausted;
// a read after the end of the message goes straight to its result, loaded once the output
// register is free. A result waits in the output register while the next input word
// is taken.
module columnar_transposition_decrypt #(
  parameter int MAX_COLUMNS = ctd_pkg::MAX_COLUMNS_DEF,
  parameter int MAX_ROWS    = ctd_pkg::MAX_ROWS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [ctd_pkg::CFG_W-1:0]  cfg_wdata,
  ctd_stream_if.sink                 in_if,
  ctd_stream_if.source               out_if
);

  localparam int CIW = $clog2(MAX_COLUMNS);
  localparam int CNW = $clog2(MAX_COLUMNS+1);
  localparam int WCW = $clog2(MAX_COLUMNS+2);
  localparam int RW  = $clog2(MAX_ROWS);
  localparam int LW  = $clog2(MAX_ROWS+1);

  ctd_pkg::ctd_state_t state_r, state_nxt;

  logic [ctd_pkg::CFG_W-1:0] col_count_r;
  logic [WCW-1:0] word_count_r, word_count_nxt;
  logic           inside_word_r, inside_word_nxt;
  logic [LW-1:0]  read_row_r, read_row_nxt;
  logic [CIW-1:0] read_col_r, read_col_nxt;
  logic           done_r, done_nxt;
  logic [CNW-1:0] cols_r, cols_nxt;
  logic [CIW-1:0] cur_col_r, cur_col_nxt;
  logic [CIW-1:0] rank_r, rank_nxt;
  logic [7:0]     byte_r, byte_nxt;
  logic [CIW-1:0] wr_word_r, wr_word_nxt;
  ctd_pkg::out_word_t res_r, res_nxt;
  logic               out_valid_r;
  ctd_pkg::out_word_t out_data_r;

  ctd_pkg::cmd_t cmd;
  logic          in_fire;
  logic          is_space;
  logic [CNW-1:0] n_clamp;
  logic [CIW-1:0] start_col;
  logic           wc_inc;
  logic [WCW-1:0] wc_after;
  logic           store_ok;
  logic [WCW-1:0] wc_word;
  logic           row_lt_len;
  logic           slot_free;
  logic           out_load;
  logic [CNW-1:0] next_col_w;

  logic           key_we;
  logic [CIW-1:0] key_waddr;
  logic           rk_start;
  logic [CIW-1:0] rk_pos;
  logic [CNW-1:0] rk_cols;
  logic           rk_done;
  logic [CIW-1:0] rk_rank;

  logic           clear;
  logic [CIW-1:0] len_raddr;
  logic [LW-1:0]  len_rdata;
  logic           len_we;
  logic [CIW-1:0] len_waddr;
  logic [LW-1:0]  len_wdata;
  logic           txt_we;
  logic           txt_re;
  logic [CIW-1:0] txt_col;
  logic [RW-1:0]  txt_row;
  logic [7:0]     txt_rdata;

  ctd_key_rank #(
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_key_rank (
    .clk       (clk),
    .rst_n     (rst_n),
    .key_we    (key_we),
    .key_waddr (key_waddr),
    .key_wdata (in_if.payload.key_value),
    .start     (rk_start),
    .pos       (rk_pos),
    .cols      (rk_cols),
    .done      (rk_done),
    .rank      (rk_rank)
  );

  ctd_text_store #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_text_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .clear     (clear),
    .len_raddr (len_raddr),
    .len_rdata (len_rdata),
    .len_we    (len_we),
    .len_waddr (len_waddr),
    .len_wdata (len_wdata),
    .txt_we    (txt_we),
    .txt_re    (txt_re),
    .txt_col   (txt_col),
    .txt_row   (txt_row),
    .txt_wdata (byte_r),
    .txt_rdata (txt_rdata)
  );

  assign cmd       = in_if.payload.command;
  assign in_if.ready = (state_r == ctd_pkg::ST_IDLE);
  assign in_fire   = in_if.valid && in_if.ready;
  assign is_space  = ((in_if.payload.text_byte >= ctd_pkg::TAB_BYTE) &&
                      (in_if.payload.text_byte <= ctd_pkg::CR_BYTE)) ||
                     (in_if.payload.text_byte == ctd_pkg::SPACE_BYTE);

  assign key_we    = in_fire && (cmd == ctd_pkg::CMD_LOAD_KEY) &&
                     ({28'd0, in_if.payload.column_index} < 32'(MAX_COLUMNS));
  assign key_waddr = CIW'(in_if.payload.column_index);

  always_comb begin
    if (col_count_r == '0) begin
      n_clamp = CNW'(1);
    end else if ({27'd0, col_count_r} > 32'(MAX_COLUMNS)) begin
      n_clamp = CNW'(MAX_COLUMNS);
    end else begin
      n_clamp = CNW'(col_count_r);
    end
  end

  // column_count may have shrunk mid-message
  assign start_col  = (CNW'(read_col_r) < n_clamp) ? read_col_r : '0;
  assign wc_inc     = !inside_word_r && (word_count_r <= WCW'(MAX_COLUMNS));
  assign wc_after   = wc_inc ? (word_count_r + WCW'(1)) : word_count_r;
  assign store_ok   = (wc_after <= WCW'(MAX_COLUMNS)) && (wc_after != '0);
  assign wc_word    = wc_after - WCW'(1);
  assign row_lt_len = read_row_r < len_rdata;
  assign slot_free  = !out_valid_r || out_if.ready;
  assign next_col_w = CNW'(cur_col_r) + CNW'(1);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ctd_pkg::ST_IDLE: begin
        if (in_fire) begin
          unique case (cmd)
            ctd_pkg::CMD_LOAD_KEY: state_nxt = ctd_pkg::ST_IDLE;
            ctd_pkg::CMD_CIPHER: begin
              if (!is_space && store_ok) begin
                state_nxt = ctd_pkg::ST_WORD_LEN;
              end
            end
            ctd_pkg::CMD_READ: begin
              state_nxt = done_r ? ctd_pkg::ST_RESULT : ctd_pkg::ST_RANK0;
            end
            ctd_pkg::CMD_RESTART: state_nxt = ctd_pkg::ST_IDLE;
            default: state_nxt = ctd_pkg::ST_IDLE;
          endcase
        end
      end
      ctd_pkg::ST_WORD_LEN: state_nxt = ctd_pkg::ST_IDLE;
      ctd_pkg::ST_RANK0: begin
        if (rk_done) begin
          state_nxt = ctd_pkg::ST_LEN0;
        end
      end
      ctd_pkg::ST_LEN0: begin
        state_nxt = row_lt_len ? ctd_pkg::ST_RANKC : ctd_pkg::ST_RESULT;
      end
      ctd_pkg::ST_RANKC: begin
        if (rk_done) begin
          state_nxt = ctd_pkg::ST_LENC;
        end
      end
      ctd_pkg::ST_LENC: begin
        state_nxt = row_lt_len ? ctd_pkg::ST_TEXT : ctd_pkg::ST_RESULT;
      end
      ctd_pkg::ST_TEXT: state_nxt = ctd_pkg::ST_RESULT;
      ctd_pkg::ST_RESULT: begin
        if (slot_free) begin
          state_nxt = ctd_pkg::ST_IDLE;
        end
      end
      default: state_nxt = ctd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    word_count_nxt  = word_count_r;
    inside_word_nxt = inside_word_r;
    read_row_nxt    = read_row_r;
    read_col_nxt    = read_col_r;
    done_nxt        = done_r;
    cols_nxt        = cols_r;
    cur_col_nxt     = cur_col_r;
    rank_nxt        = rank_r;
    byte_nxt        = byte_r;
    wr_word_nxt     = wr_word_r;
    res_nxt         = res_r;
    rk_start        = 1'b0;
    rk_pos          = '0;
    rk_cols         = cols_r;
    clear           = 1'b0;
    len_raddr       = '0;
    len_we          = 1'b0;
    len_waddr       = wr_word_r;
    len_wdata       = LW'(len_rdata + LW'(1));
    txt_we          = 1'b0;
    txt_re          = 1'b0;
    txt_col         = '0;
    txt_row         = '0;
    out_load        = 1'b0;
    unique case (state_r)
      ctd_pkg::ST_IDLE: begin
        if (in_fire) begin
          unique case (cmd)
            ctd_pkg::CMD_LOAD_KEY: begin
              rk_pos = '0;
            end
            ctd_pkg::CMD_CIPHER: begin
              if (is_space) begin
                inside_word_nxt = 1'b0;
              end else begin
                inside_word_nxt = 1'b1;
                word_count_nxt  = wc_after;
                if (store_ok) begin
                  len_raddr   = wc_word[CIW-1:0];
                  wr_word_nxt = wc_word[CIW-1:0];
                  byte_nxt    = in_if.payload.text_byte;
                end
              end
            end
            ctd_pkg::CMD_READ: begin
              if (done_r) begin
                res_nxt = '{plain_byte: 8'd0, byte_valid: 1'b0, finished: 1'b1};
              end else begin
                cols_nxt    = n_clamp;
                cur_col_nxt = start_col;
                rk_start    = 1'b1;
                rk_pos      = '0;
                rk_cols     = n_clamp;
              end
            end
            ctd_pkg::CMD_RESTART: begin
              clear           = 1'b1;
              word_count_nxt  = '0;
              inside_word_nxt = 1'b0;
              read_row_nxt    = '0;
              read_col_nxt    = '0;
              done_nxt        = 1'b0;
            end
            default: begin
              rk_pos = '0;
            end
          endcase
        end
      end
      ctd_pkg::ST_WORD_LEN: begin
        if (len_rdata < LW'(MAX_ROWS)) begin
          txt_we  = 1'b1;
          txt_col = wr_word_r;
          txt_row = len_rdata[RW-1:0];
          len_we  = 1'b1;
        end
      end
      ctd_pkg::ST_RANK0: begin
        if (rk_done) begin
          len_raddr = rk_rank;
        end
      end
      ctd_pkg::ST_LEN0: begin
        if (row_lt_len) begin
          rk_start = 1'b1;
          rk_pos   = cur_col_r;
          rk_cols  = cols_r;
        end else begin
          done_nxt = 1'b1;
          res_nxt  = '{plain_byte: 8'd0, byte_valid: 1'b0, finished: 1'b1};
        end
      end
      ctd_pkg::ST_RANKC: begin
        if (rk_done) begin
          len_raddr = rk_rank;
          rank_nxt  = rk_rank;
        end
      end
      ctd_pkg::ST_LENC: begin
        if (row_lt_len) begin
          txt_re  = 1'b1;
          txt_col = rank_r;
          txt_row = read_row_r[RW-1:0];
        end else begin
          done_nxt = 1'b1;
          res_nxt  = '{plain_byte: 8'd0, byte_valid: 1'b0, finished: 1'b1};
        end
      end
      ctd_pkg::ST_TEXT: begin
        if (txt_rdata != ctd_pkg::HASH_BYTE) begin
          res_nxt.plain_byte = (txt_rdata == ctd_pkg::UNDERSCORE_BYTE) ?
                               ctd_pkg::SPACE_BYTE : txt_rdata;
          res_nxt.byte_valid = 1'b1;
          res_nxt.finished   = 1'b0;
          if (next_col_w >= cols_r) begin
            read_col_nxt = '0;
            read_row_nxt = read_row_r + LW'(1);
          end else begin
            read_col_nxt = next_col_w[CIW-1:0];
          end
        end else begin
          done_nxt = 1'b1;
          res_nxt  = '{plain_byte: 8'd0, byte_valid: 1'b0, finished: 1'b1};
        end
      end
      ctd_pkg::ST_RESULT: begin
        out_load = slot_free;
      end
      default: begin
        out_load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ctd_pkg::ST_IDLE;
      col_count_r   <= ctd_pkg::CFG_W'(1);
      word_count_r  <= '0;
      inside_word_r <= 1'b0;
      read_row_r    <= '0;
      read_col_r    <= '0;
      done_r        <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      word_count_r  <= word_count_nxt;
      inside_word_r <= inside_word_nxt;
      read_row_r    <= read_row_nxt;
      read_col_r    <= read_col_nxt;
      done_r        <= done_nxt;
      if (cfg_we) begin
        col_count_r <= cfg_wdata;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cols_r    <= cols_nxt;
    cur_col_r <= cur_col_nxt;
    rank_r    <= rank_nxt;
    byte_r    <= byte_nxt;
    wr_word_r <= wr_word_nxt;
    res_r     <= res_nxt;
    if (out_load) begin
      out_data_r <= res_r;
    end
  end

  assign out_if.valid   = out_valid_r;
  assign out_if.payload = out_data_r;

endmodule

// File: hdl/ctd_checker.sv
`timescale 1ns / 1ps
`include "columnar_transposition_decrypt_macros.svh"
module ctd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_plain_byte,
  input logic       out_byte_valid,
  input logic       out_finished
);

  // a stalled result word holds
  `CTD_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_plain_byte) && $stable(out_byte_valid) && $stable(out_finished))

  // every result is either a byte or the end of the message
  `CTD_ASSERT_IMP(a_byte_xor_end, clk, rst_n, out_valid, out_byte_valid ^ out_finished)

  // underscores are given as spaces and the end marker is never passed on
  `CTD_ASSERT_IMP(a_no_marker, clk, rst_n, out_valid && out_byte_valid, (out_plain_byte != ctd_pkg::UNDERSCORE_BYTE) && (out_plain_byte != ctd_pkg::HASH_BYTE))

  // an end-of-message result carries a zero byte
  `CTD_ASSERT_IMP(a_end_zero, clk, rst_n, out_valid && !out_byte_valid, out_plain_byte == 8'd0)

endmodule

bind columnar_transposition_decrypt ctd_checker u_ctd_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_if.valid),
  .out_ready      (out_if.ready),
  .out_plain_byte (out_if.payload.plain_byte),
  .out_byte_valid (out_if.payload.byte_valid),
  .out_finished   (out_if.payload.finished)
);

// File: tb/tb.sv
`timescale 1ns / 1ps
module tb;

  localparam int MAXC = ctd_pkg::MAX_COLUMNS_DEF;
  localparam int MAXR = ctd_pkg::MAX_ROWS_DEF;
  localparam ctd_pkg::out_word_t MSG_END = '{plain_byte: 8'h00, byte_valid: 1'b0,
                                             finished: 1'b1};

  typedef struct {
    ctd_pkg::in_word_t  w;
    bit                 typed;
    ctd_pkg::out_word_t res;
  } plan_row_t;

  logic                      clk;
  logic                      rst_n;
  logic                      cfg_we;
  logic [ctd_pkg::CFG_W-1:0] cfg_wdata;

  ctd_stream_if #(.payload_t(ctd_pkg::in_word_t))  in_ch ();
  ctd_stream_if #(.payload_t(ctd_pkg::out_word_t)) out_ch ();

  columnar_transposition_decrypt dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_if     (in_ch),
    .out_if    (out_ch)
  );

  // shadow of the decrypter state
  logic [7:0]                key_tab [MAXC];
  logic [7:0]                text_mem [MAXC*MAXR];
  int                        word_len [MAXC];
  int                        word_cnt;
  bit                        in_word;
  int                        rd_row;
  int                        rd_col;
  bit                        msg_done;
  logic [ctd_pkg::CFG_W-1:0] col_cfg;

  ctd_pkg::out_word_t plain_expected [$];
  int        mismatches = 0;
  int        items_sent = 0;
  int        idle_mode = 0;
  int        send_idle [3] = '{13, 53, 0};
  int        recv_idle [3] = '{53, 13, 0};
  bit        out_hold_req = 1'b0;
  bit        hold_pending = 1'b0;

  plan_row_t plan [24] = '{
    '{'{ctd_pkg::CMD_READ,     4'd0,  8'h00, 8'h00},                     1'b1, MSG_END},
    '{'{ctd_pkg::CMD_RESTART,  4'd9,  8'hA5, 8'h5A},                     1'b0, '0},
    '{'{ctd_pkg::CMD_LOAD_KEY, 4'd0,  8'hFF, 8'h00},                     1'b0, '0},
    '{'{ctd_pkg::CMD_LOAD_KEY, 4'd1,  8'h00, 8'hFF},                     1'b0, '0},
    '{'{ctd_pkg::CMD_LOAD_KEY, 4'd2,  8'h80, 8'h00},                     1'b0, '0},
    '{'{ctd_pkg::CMD_LOAD_KEY, 4'd15, 8'h55, 8'h00},                     1'b0, '0},
    '{'{ctd_pkg::CMD_CIPHER,   4'd15, 8'hFF, 8'h41},                     1'b0, '0},
    '{'{ctd_pkg::CMD_CIPHER,   4'd0,  8'h00, ctd_pkg::UNDERSCORE_BYTE},  1'b0, '0},
    '{'{ctd_pkg::CMD_CIPHER,   4'd0,  8'h00, ctd_pkg::TAB_BYTE},         1'b0, '0},
    '{'{ctd_pkg::CMD_CIPHER,   4'd0,  8'h00, ctd_pkg::CR_BYTE},          1'b0, '0},
    '{'{ctd_pkg::CMD_CIPHER,   4'd0,  8'h00, 8'h42},                     1'b0, '0},
    '{'{ctd_pkg::CMD_CIPHER,   4'd0,  8'h00, 8'hFF},                     1'b0, '0},
    '{'{ctd_pkg::CMD_CIPHER,   4'd0,  8'h00, ctd_pkg::SPACE_BYTE},       1'b0, '0},
    '{'{ctd_pkg::CMD_CIPHER,   4'd0,  8'h00, 8'h00},                     1'b0, '0},
    '{'{ctd_pkg::CMD_CIPHER,   4'd0,  8'h00, 8'hFE},                     1'b0, '0},
    '{'{ctd_pkg::CMD_CIPHER,   4'd0,  8'h00, ctd_pkg::HASH_BYTE},        1'b0, '0},
    '{'{ctd_pkg::CMD_READ,     4'd15, 8'hFF, 8'hFF},                     1'b0, '0},
    '{'{ctd_pkg::CMD_READ,     4'd0,  8'h00, 8'h00},                     1'b0, '0},
    '{'{ctd_pkg::CMD_READ,     4'd0,  8'h00, 8'h00},                     1'b0, '0},
    '{'{ctd_pkg::CMD_READ,     4'd0,  8'h00, 8'h00},                     1'b0, '0},
    '{'{ctd_pkg::CMD_READ,     4'd0,  8'h00, 8'h00},                     1'b0, '0},
    '{'{ctd_pkg::CMD_READ,     4'd0,  8'h00, 8'h00},                     1'b0, '0},
    '{'{ctd_pkg::CMD_READ,     4'd0,  8'h00, 8'h00},                     1'b1, MSG_END},
    '{'{ctd_pkg::CMD_READ,     4'd0,  8'h00, 8'h00},                     1'b1, MSG_END}
  };

  function automatic void clear_words();
    foreach (word_len[i]) word_len[i] = 0;
    word_cnt = 0;
    in_word  = 1'b0;
    rd_row   = 0;
    rd_col   = 0;
    msg_done = 1'b0;
  endfunction

  function automatic int cols_in_use();
    if (col_cfg == 0) return 1;
    if (col_cfg > MAXC) return MAXC;
    return int'(col_cfg);
  endfunction

  function automatic int rank_at(input int c, input int n);
    int r;
    r = 0;
    for (int j = 0; j < n; j++)
      if (key_tab[j] < key_tab[c]) r++;
    return r;
  endfunction

  function automatic int rank_len(input int r);
    if (r >= word_cnt || r >= MAXC) return 0;
    return word_len[r];
  endfunction

  function automatic void decrypt_step(input ctd_pkg::in_word_t w, output bit gives,
                                       output ctd_pkg::out_word_t res);
    int         n, c, r;
    logic [7:0] b;
    bit         ok;
    gives = 1'b0;
    res   = '0;
    b     = 8'h00;
    ok    = 1'b0;
    case (w.command)
      ctd_pkg::CMD_LOAD_KEY: key_tab[w.column_index] = w.key_value;
      ctd_pkg::CMD_CIPHER: begin
        if ((w.text_byte >= ctd_pkg::TAB_BYTE && w.text_byte <= ctd_pkg::CR_BYTE) ||
            w.text_byte == ctd_pkg::SPACE_BYTE) begin
          in_word = 1'b0;
        end else begin
          if (!in_word) begin
            in_word = 1'b1;
            if (word_cnt <= MAXC) word_cnt++;
          end
          if (word_cnt <= MAXC && word_len[word_cnt-1] < MAXR) begin
            text_mem[(word_cnt-1)*MAXR + word_len[word_cnt-1]] = w.text_byte;
            word_len[word_cnt-1]++;
          end
        end
      end
      ctd_pkg::CMD_RESTART: clear_words();
      default: begin
        n = cols_in_use();
        c = (rd_col >= n) ? 0 : rd_col;
        if (!msg_done) begin
          if (rd_row < rank_len(rank_at(0, n))) begin
            r = rank_at(c, n);
            if (rd_row < rank_len(r)) begin
              b  = text_mem[r*MAXR + rd_row];
              ok = (b != ctd_pkg::HASH_BYTE);
            end
          end
          if (ok) begin
            c++;
            if (c >= n) begin
              c = 0;
              rd_row++;
            end
            rd_col = c;
            if (b == ctd_pkg::UNDERSCORE_BYTE) b = ctd_pkg::SPACE_BYTE;
          end else begin
            msg_done = 1'b1;
          end
        end
        gives          = 1'b1;
        res.plain_byte = ok ? b : 8'h00;
        res.byte_valid = ok;
        res.finished   = !ok;
      end
    endcase
  endfunction

  task automatic push_word(input ctd_pkg::in_word_t w, input bit typed,
                           input ctd_pkg::out_word_t typed_res);
    bit                 gives;
    ctd_pkg::out_word_t res;
    while ($urandom_range(99) < send_idle[idle_mode]) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.payload = w;
    in_ch.valid   = 1'b1;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    decrypt_step(w, gives, res);
    if (gives) plain_expected.insert(plain_expected.size(), typed ? typed_res : res);
    items_sent++;
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  task automatic offer(input ctd_pkg::cmd_t c, input logic [3:0] i, input logic [7:0] k,
                       input logic [7:0] t);
    ctd_pkg::in_word_t w;
    w = '{command: c, column_index: i, key_value: k, text_byte: t};
    push_word(w, 1'b0, '0);
  endtask

  function automatic logic [7:0] blank_byte();
    int r;
    r = $urandom_range(5);
    return (r == 5) ? ctd_pkg::SPACE_BYTE : ctd_pkg::TAB_BYTE + 8'(r);
  endfunction

  function automatic logic [7:0] text_char();
    int         r;
    logic [7:0] b;
    r = $urandom_range(99);
    if (r < 10) return ctd_pkg::UNDERSCORE_BYTE;
    if (r < 13) return ctd_pkg::HASH_BYTE;
    if (r < 20) begin
      do b = 8'($urandom_range(255));
      while ((b >= ctd_pkg::TAB_BYTE && b <= ctd_pkg::CR_BYTE) || b == ctd_pkg::SPACE_BYTE);
      return b;
    end
    return 8'($urandom_range(8'h21, 8'h7E));
  endfunction

  task automatic send_message();
    int         n, nw, rows, len, top, reads, r;
    logic [7:0] kmax;
    n = cols_in_use();
    if ($urandom_range(9) < 7) begin
      kmax = $urandom_range(1) ? 8'd7 : 8'd255;
      top  = ($urandom_range(3) == 0) ? $urandom_range(15, n-1) : n-1;
      for (int j = 0; j <= top; j++)
        offer(ctd_pkg::CMD_LOAD_KEY, 4'(j), 8'($urandom_range(kmax)),
              8'($urandom_range(255)));
    end
    if ($urandom_range(9) != 0)
      offer(ctd_pkg::CMD_RESTART, 4'($urandom_range(15)), 8'($urandom_range(255)),
            8'($urandom_range(255)));
    rows = $urandom_range(1, 4);
    nw   = n;
    case ($urandom_range(11))
      0: nw = n + 1;
      1: nw = (n > 1) ? n - 1 : n;
      2: if (n >= 14) nw = MAXC + 2;
      default: ;
    endcase
    if ($urandom_range(3) == 0) offer(ctd_pkg::CMD_CIPHER, 4'd0, 8'd0, blank_byte());
    for (int k = 0; k < nw; k++) begin
      len = rows;
      if ($urandom_range(4) == 0) len = $urandom_range(1, rows + 1);
      if ($urandom_range(39) == 0) len = $urandom_range(MAXR + 3, MAXR - 1);
      for (int i = 0; i < len; i++)
        offer(ctd_pkg::CMD_CIPHER, 4'($urandom_range(15)), 8'($urandom_range(255)),
              text_char());
      repeat ($urandom_range(1, 2))
        offer(ctd_pkg::CMD_CIPHER, 4'($urandom_range(15)), 8'($urandom_range(255)),
              blank_byte());
    end
    reads = rows * n + $urandom_range(1, 3);
    if (hold_pending) begin
      hold_pending = 1'b0;
      out_hold_req = 1'b1;
    end
    repeat (reads) begin
      r = $urandom_range(99);
      if (r < 3)
        offer(ctd_pkg::CMD_CIPHER, 4'($urandom_range(15)), 8'($urandom_range(255)),
              8'($urandom_range(255)));
      else if (r < 5)
        offer(ctd_pkg::cmd_t'($urandom_range(3)), 4'($urandom_range(15)),
              8'($urandom_range(255)), 8'($urandom_range(255)));
      offer(ctd_pkg::CMD_READ, 4'($urandom_range(15)), 8'($urandom_range(255)),
            8'($urandom_range(255)));
    end
  endtask

  task automatic settle();
    in_ch.valid = 1'b0;
    while (plain_expected.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  task automatic write_cfg(input logic [ctd_pkg::CFG_W-1:0] v);
    cfg_we    = 1'b1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we    = 1'b0;
    col_cfg   = v;
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("tb NOT OK");
    $finish;
  end

  // result side
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (out_hold_req) begin
        out_hold_req = 1'b0;
        out_ch.ready = 1'b0;
        repeat (400) @(negedge clk);
      end
      out_ch.ready = ($urandom_range(99) >= recv_idle[idle_mode]);
    end
  end

  always @(posedge clk) begin
    ctd_pkg::out_word_t got, want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got = out_ch.payload;
      if (plain_expected.size() == 0) begin
        $error("unexpected word: plain_byte %0h byte_valid %0b finished %0b",
               got.plain_byte, got.byte_valid, got.finished);
        mismatches++;
      end else begin
        want = plain_expected.pop_front();
        if (got.plain_byte !== want.plain_byte) begin
          $error("plain_byte expected %0h actual %0h", want.plain_byte, got.plain_byte);
          mismatches++;
        end
        if (got.byte_valid !== want.byte_valid) begin
          $error("byte_valid expected %0b actual %0b", want.byte_valid, got.byte_valid);
          mismatches++;
        end
        if (got.finished !== want.finished) begin
          $error("finished expected %0b actual %0b", want.finished, got.finished);
          mismatches++;
        end
      end
    end
  end

  initial begin
    logic [ctd_pkg::CFG_W-1:0] cfg_plan [6];
    int                        phase_start;
    cfg_plan      = '{5'd16, 5'd0, 5'd31, 5'd2, 5'd1, 5'd7};
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    in_ch.valid   = 1'b0;
    in_ch.payload = '0;
    foreach (key_tab[i]) key_tab[i] = 8'h00;
    col_cfg = 5'd1;
    clear_words();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    write_cfg(5'd3);
    foreach (plan[i]) push_word(plan[i].w, plan[i].typed, plan[i].res);
    for (int p = 0; p < 6; p++) begin
      settle();
      idle_mode = p / 2;
      write_cfg(cfg_plan[p]);
      if (p == 1) hold_pending = 1'b1;
      phase_start = items_sent;
      while (items_sent - phase_start < 200) send_message();
    end
    settle();
    if (mismatches == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end
endmodule

// File: files.f
+incdir+hdl
hdl/ctd_pkg.sv
hdl/ctd_stream_if.sv
hdl/ctd_key_rank.sv
hdl/ctd_text_store.sv
hdl/columnar_transposition_decrypt.sv
hdl/ctd_checker.sv
tb/tb.sv
